FILE: design/cbls_pkg.sv
`timescale 1ns / 1ps
// Package: payload types, sizing constants and Bernstein weight tables for the link sampler.
package cbls_pkg;

  localparam int CRD_W      = 20;
  localparam int EXT_W      = 12;
  localparam int SAMPLES    = 30;
  localparam int N_STUB_LIM = 30;
  localparam int N_FREE_LIM = 32;
  localparam int MIN_TAN2   = 128;

  // Points per curve, with and without stubs
  localparam int N_S = (SAMPLES < 2) ? 2 : ((SAMPLES > N_STUB_LIM) ? N_STUB_LIM : SAMPLES);
  localparam int N_F = (SAMPLES < 2) ? 2 : ((SAMPLES > N_FREE_LIM) ? N_FREE_LIM : SAMPLES);
  localparam int M_S = N_S - 1;
  localparam int M_F = N_F - 1;

  // Divisor 2*m^3 for the exact rounding step
  localparam int K_S  = 2 * M_S * M_S * M_S;
  localparam int K_F  = 2 * M_F * M_F * M_F;
  localparam int KMAX = (K_S > K_F) ? K_S : K_F;
  localparam int KMIN = (K_S < K_F) ? K_S : K_F;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int AW   = $clog2(KMAX / 2 + 1);
  localparam int BW   = AW + 1;

  localparam int NPTS = N_F;
  localparam int IW   = $clog2(NPTS);
  localparam int RMAX = (N_S + 2 > N_F) ? N_S + 2 : N_F;
  localparam int CW   = $clog2(RMAX);

  localparam int XW = CRD_W + 1;   // shifted curve start and end x
  localparam int YW = CRD_W + 1;   // end y minus start y
  localparam int DW = CRD_W + 2;   // end x minus start x of the curve
  localparam int TW = CRD_W + 1;   // doubled tangent length
  localparam int QB = CRD_W + 2;   // quotient bits, offset binary
  localparam int NW = KW + QB;     // dividend width
  localparam int SW = NW + 1;      // signed numerator width
  localparam int OW = CRD_W + 3;   // unsaturated point width

  // Reciprocal of 2*m^3, scaled by 2^RS, exact for every NW-bit dividend
  localparam int RS  = NW + KW;
  localparam int RW  = RS - $clog2(KMIN + 1) + 2;
  localparam int SPL = (RW + 1) / 2;   // split point of dividend and reciprocal
  localparam int NH  = NW - SPL;
  localparam int RH  = RW - SPL;
  localparam int FW  = NW + RW;        // full product width
  localparam int HHW = NH + RH;
  localparam int HLW = NH + SPL;
  localparam int LHW = SPL + RH;
  localparam int LLW = 2 * SPL;
  localparam int MDW = RW + 1;

  localparam logic [KW-1:0] K_S_V = KW'(K_S);
  localparam logic [KW-1:0] K_F_V = KW'(K_F);

  localparam logic [RW-1:0] R_S_V = RW'(((64'd1 << RS) + 64'(K_S) - 64'd1) / 64'(K_S));
  localparam logic [RW-1:0] R_F_V = RW'(((64'd1 << RS) + 64'(K_F) - 64'd1) / 64'(K_F));

  localparam logic signed [OW-1:0] SAT_HI = OW'((1 << (CRD_W - 1)) - 1);
  localparam logic signed [OW-1:0] SAT_LO = OW'(-(1 << (CRD_W - 1)));

  typedef logic signed [CRD_W-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last;
  } out_item_t;

  typedef logic        [AW-1:0] wa_t;
  typedef logic signed [BW-1:0] wb_t;
  typedef wa_t [NPTS-1:0] wa_tab_t;
  typedef wb_t [NPTS-1:0] wb_tab_t;

  // Sideband that rides with each point down the pipe
  typedef struct packed {
    logic                 cur;
    logic                 last;
    logic                 stub;
    logic signed [XW-1:0] base_x;
    coord_t               base_y;
  } side_t;

  typedef struct packed {
    side_t                sd;
    logic signed [DW-1:0] dx;
    logic signed [YW-1:0] dy;
    wa_t                  a;
    wb_t                  b;
  } p1_t;

  typedef struct packed {
    side_t                sd;
    logic signed [DW-1:0] dx;
    logic signed [YW-1:0] dy;
    wa_t                  a;
    wb_t                  b;
    logic        [TW-1:0] t2;
  } p2_t;

  typedef struct packed {
    side_t                sd;
    logic signed [SW-1:0] px;
    logic signed [SW-1:0] tx;
    logic signed [SW-1:0] py;
  } p3_t;

  typedef struct packed {
    side_t         sd;
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
  } p4_t;

  typedef struct packed {
    side_t          sd;
    logic [HHW-1:0] xhh;
    logic [HLW-1:0] xhl;
    logic [LHW-1:0] xlh;
    logic [LLW-1:0] xll;
    logic [HHW-1:0] yhh;
    logic [HLW-1:0] yhl;
    logic [LHW-1:0] ylh;
    logic [LLW-1:0] yll;
  } p5_t;

  typedef struct packed {
    side_t          sd;
    logic [FW-1:0]  xcat;
    logic [MDW-1:0] xmid;
    logic [FW-1:0]  ycat;
    logic [MDW-1:0] ymid;
  } p6_t;

  typedef struct packed {
    side_t         sd;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
  } p7_t;

  // Weight of the end-point difference: 3*j*i^2 + i^3
  function automatic wa_tab_t build_a(input int m);
    wa_tab_t tab;
    int      j;
    for (int i = 0; i < NPTS; i++) begin
      j = m - i;
      tab[i] = (i <= m) ? AW'(3 * j * i * i + i * i * i) : '0;
    end
    return tab;
  endfunction

  // Weight of the tangent: 3*j*i*(j - i)
  function automatic wb_tab_t build_b(input int m);
    wb_tab_t tab;
    int      j;
    for (int i = 0; i < NPTS; i++) begin
      j = m - i;
      tab[i] = (i <= m) ? BW'(3 * j * i * (j - i)) : '0;
    end
    return tab;
  endfunction

  localparam wa_tab_t A_TAB_S = build_a(M_S);
  localparam wa_tab_t A_TAB_F = build_a(M_F);
  localparam wb_tab_t B_TAB_S = build_b(M_S);
  localparam wb_tab_t B_TAB_F = build_b(M_F);

  function automatic coord_t sat_coord(input logic signed [OW-1:0] v);
    coord_t r;
    if (v > SAT_HI) begin
      r = CRD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = CRD_W'(SAT_LO);
    end else begin
      r = CRD_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/cubic_bezier_link_sampler_core.sv
`timescale 1ns / 1ps
// Top level: cubic Bezier connector sampler, sequencer plus deep point pipeline.
//
//  channel | signals                         | moves
//  --------+---------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data     | one item: start and end point
//  output  | out_valid, out_ready, out_data  | one sampled point, last on the final
//  config  | cfg_wr_en, cfg_wr_data          | link_extension, registered on a write
//
// An item gives N_S+2 points with stubs, N_F without (32 and 30 at the default
// size); the sequencer issues one point per cycle while the output is not stalled.
// The first point of an item passes the sequencer, seven pipe stages and the output
// register before out_valid rises; three of the stages do the reciprocal divide by 2*m^3.
// Reset clears the register, the sequencer and all stage valid bits.
// A stalled output freezes the whole pipe; the next item is taken on the
// cycle the last point of the current one issues.
module cubic_bezier_link_sampler_core
  import cbls_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [EXT_W-1:0] cfg_wr_data
);

  logic [EXT_W-1:0]     ext;
  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_last;
  logic                 stub;
  coord_t               sx, sy, ex, ey;
  logic signed [XW-1:0] b0x, b3x;

  logic                 adv;
  logic                 accept;

  logic                 v1, v2, v3, v4, v5, v6, v7;
  p1_t                  p1, p1_next;
  p2_t                  p2, p2_next;
  p3_t                  p3, p3_next;
  p4_t                  p4, p4_next;
  p5_t                  p5, p5_next;
  p6_t                  p6, p6_next;
  p7_t                  p7, p7_next;
  out_item_t            out_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !busy || (adv && (cnt == cnt_last));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext <= '0;
    end else if (cfg_wr_en) begin
      ext <= cfg_wr_data;
    end
  end

  // Sequencer: one slot per cycle unless stalled; stub start, curve samples, stub end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && adv) begin
      if (cnt == cnt_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx       <= in_data.start_x;
      sy       <= in_data.start_y;
      ex       <= in_data.end_x;
      ey       <= in_data.end_y;
      stub     <= (ext != '0);
      cnt_last <= (ext != '0) ? CW'(N_S + 1) : CW'(N_F - 1);
      b0x      <= XW'(in_data.start_x) + XW'(ext);
      b3x      <= XW'(in_data.end_x) - XW'(ext);
    end
  end

  always_comb begin
    logic          first_slot;
    logic          end_slot;
    logic [IW-1:0] idx;
    first_slot = stub && (cnt == '0);
    end_slot   = stub && (cnt == cnt_last);
    idx        = IW'(cnt - CW'(stub));
    p1_next.sd.cur    = !first_slot && !end_slot;
    p1_next.sd.last   = (cnt == cnt_last);
    p1_next.sd.stub   = stub;
    p1_next.sd.base_x = first_slot ? XW'(sx) : (end_slot ? XW'(ex) : b0x);
    p1_next.sd.base_y = end_slot ? ey : sy;
    p1_next.dx        = DW'(b3x) - DW'(b0x);
    p1_next.dy        = YW'(ey) - YW'(sy);
    p1_next.a         = stub ? A_TAB_S[idx] : A_TAB_F[idx];
    p1_next.b         = stub ? B_TAB_S[idx] : B_TAB_F[idx];
  end

  // Tangent length, at least the minimum
  always_comb begin
    logic [DW-1:0] mag;
    mag = p1.dx[DW-1] ? DW'(-p1.dx) : DW'(p1.dx);
    p2_next.sd = p1.sd;
    p2_next.dx = p1.dx;
    p2_next.dy = p1.dy;
    p2_next.a  = p1.a;
    p2_next.b  = p1.b;
    p2_next.t2 = (TW'(mag) < TW'(MIN_TAN2)) ? TW'(MIN_TAN2) : TW'(mag);
  end

  // Weighted terms, numerators in doubled units
  always_comb begin
    p3_next.sd = p2.sd;
    p3_next.px = $signed({p2.dx, 1'b0}) * $signed({1'b0, p2.a});
    p3_next.tx = $signed({1'b0, p2.t2}) * $signed(p2.b);
    p3_next.py = $signed({p2.dy, 1'b0}) * $signed({1'b0, p2.a});
  end

  // Add the rounding half step and an offset that keeps the dividend positive
  always_comb begin
    logic [KW-1:0]        kd;
    logic signed [SW-1:0] off;
    logic signed [SW-1:0] nx;
    logic signed [SW-1:0] ny;
    kd  = p3.sd.stub ? K_S_V : K_F_V;
    off = SW'(kd) << (QB - 1);
    nx  = p3.px + p3.tx + SW'(kd >> 1) + off;
    ny  = p3.py + SW'(kd >> 1) + off;
    p4_next.sd = p3.sd;
    p4_next.rx = NW'(nx);
    p4_next.ry = NW'(ny);
  end

  // Exact floor division by 2*m^3: multiply by the scaled reciprocal in halves
  always_comb begin
    logic [RW-1:0] r;
    r = p4.sd.stub ? R_S_V : R_F_V;
    p5_next.sd  = p4.sd;
    p5_next.xhh = HHW'(p4.rx[NW-1:SPL]) * HHW'(r[RW-1:SPL]);
    p5_next.xhl = HLW'(p4.rx[NW-1:SPL]) * HLW'(r[SPL-1:0]);
    p5_next.xlh = LHW'(p4.rx[SPL-1:0]) * LHW'(r[RW-1:SPL]);
    p5_next.xll = LLW'(p4.rx[SPL-1:0]) * LLW'(r[SPL-1:0]);
    p5_next.yhh = HHW'(p4.ry[NW-1:SPL]) * HHW'(r[RW-1:SPL]);
    p5_next.yhl = HLW'(p4.ry[NW-1:SPL]) * HLW'(r[SPL-1:0]);
    p5_next.ylh = LHW'(p4.ry[SPL-1:0]) * LHW'(r[RW-1:SPL]);
    p5_next.yll = LLW'(p4.ry[SPL-1:0]) * LLW'(r[SPL-1:0]);
  end

  // Outer products do not overlap, so they pack side by side
  always_comb begin
    p6_next.sd   = p5.sd;
    p6_next.xcat = {p5.xhh, p5.xll};
    p6_next.xmid = MDW'(p5.xhl) + MDW'(p5.xlh);
    p6_next.ycat = {p5.yhh, p5.yll};
    p6_next.ymid = MDW'(p5.yhl) + MDW'(p5.ylh);
  end

  // Full product; the quotient sits above the reciprocal scale
  always_comb begin
    logic [FW-1:0] fx;
    logic [FW-1:0] fy;
    fx = p6.xcat + (FW'(p6.xmid) << SPL);
    fy = p6.ycat + (FW'(p6.ymid) << SPL);
    p7_next.sd = p6.sd;
    p7_next.qx = fx[RS +: QB];
    p7_next.qy = fy[RS +: QB];
  end

  // Drop the offset, add to the curve start for curve points, saturate
  always_comb begin
    logic signed [QB-1:0] qxs;
    logic signed [QB-1:0] qys;
    logic signed [OW-1:0] sum_x;
    logic signed [OW-1:0] sum_y;
    qxs   = {~p7.qx[QB-1], p7.qx[QB-2:0]};
    qys   = {~p7.qy[QB-1], p7.qy[QB-2:0]};
    sum_x = OW'(p7.sd.base_x) + (p7.sd.cur ? OW'(qxs) : OW'(0));
    sum_y = OW'(p7.sd.base_y) + (p7.sd.cur ? OW'(qys) : OW'(0));
    out_next.point_x = sat_coord(sum_x);
    out_next.point_y = sat_coord(sum_y);
    out_next.last    = p7.sd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= busy;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  // Hold all stage data while the output is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      p1       <= p1_next;
      p2       <= p2_next;
      p3       <= p3_next;
      p4       <= p4_next;
      p5       <= p5_next;
      p6       <= p6_next;
      p7       <= p7_next;
      out_data <= out_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= cnt_last)
    else $error("sequencer count past the final slot");

  a_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && cnt == '0)
    else $error("accepted item did not start at the first slot");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    accept && busy |-> adv && cnt == cnt_last)
    else $error("item taken while the current one still has slots");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && adv && cnt == cnt_last && !accept |=> !busy)
    else $error("sequencer did not go idle after its final slot");

endmodule
